// File: sv/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared types and constants of the thick line rasterizer.
// ----------------------------------------------------------------------------
package tlr_pkg;

   // command kinds handed from the front end to the walker
   typedef enum logic [1:0] {
      CMD_RECT,
      CMD_LINE,
      CMD_NEXT
   } cmd_type;

   // request op codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   // register indexes
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   // register reset values
   localparam int SCREEN_WIDTH_RESET  = 320;
   localparam int SCREEN_HEIGHT_RESET = 240;

   // fixed field widths
   localparam int COORD_IN_W = 16;
   localparam int COLOR_IN_W = 16;
   localparam int STROKE_W   = 6;
   localparam int CSR_W      = 13;
   localparam int RECT_POS_W = 13;
   localparam int RECT_DIM_W = 12;

   // command queue depth, a power of two
   localparam int QUEUE_DEPTH = 4;

endpackage

// File: sv/thick_line_rasterizer.sv
// ----------------------------------------------------------------------------
// thick_line_rasterizer
// Turns lines between two screen points into a stream of filled rectangles.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  op, endpoints, color, stroke
//   rsp_      out        rsp_valid/rsp_stall  rectangle, color, last
//   csr_      in         csr_write_en         index, write data
//
// One request per cycle sustained while the queue has room; the walker makes one
// rectangle per cycle while the result port is not stalled. A request's rectangle
// passes the clamp stage register, loaded at the transfer edge, then the command
// queue, then the walker output register on its way to the result port.
// A four-entry command queue lets the front end keep taking requests while
// the result port is stalled; req_stall rises only when the queue is full.
// Synchronous reset clears the queue, the active line and rsp_valid, and
// sets the screen to 320 by 240.
//
module thick_line_rasterizer import tlr_pkg::*; #(
   parameter int MAX_SCREEN_SIZE = 4096,
   parameter int COLOR_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic signed [COORD_IN_W-1:0]  req_start_x,
   input  logic signed [COORD_IN_W-1:0]  req_start_y,
   input  logic signed [COORD_IN_W-1:0]  req_end_x,
   input  logic signed [COORD_IN_W-1:0]  req_end_y,
   input  logic [COLOR_IN_W-1:0]         req_line_color,
   input  logic [STROKE_W-1:0]           req_stroke_width,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [RECT_POS_W-1:0]  rsp_rect_x,
   output logic signed [RECT_POS_W-1:0]  rsp_rect_y,
   output logic [RECT_DIM_W-1:0]         rsp_rect_w,
   output logic [RECT_DIM_W-1:0]         rsp_rect_h,
   output logic [COLOR_IN_W-1:0]         rsp_rect_color,
   output logic                          rsp_last,
   // register writes
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [CSR_W-1:0]              csr_wdata
);

   localparam int CW = $clog2(MAX_SCREEN_SIZE);
   localparam int SZ = (CW > STROKE_W) ? CW : STROKE_W;
   localparam int CB = (COLOR_BITS < COLOR_IN_W) ? COLOR_BITS : COLOR_IN_W;

   typedef struct packed {
      cmd_type             kind;
      logic signed [SZ:0]  pos_a;
      logic signed [SZ:0]  pos_b;
      logic [SZ-1:0]       size_a;
      logic [SZ-1:0]       size_b;
      logic [CW-1:0]       major_end;
      logic                swapped;
      logic [CB-1:0]       color;
      logic [STROKE_W-1:0] stroke;
   } qent_type;

   qent_type push_ent, pop_ent;
   logic     push_valid, push_ready, pop_valid, pop;

   // front end: clamp and classify
   tlr_front #(
      .MAX_SCREEN_SIZE (MAX_SCREEN_SIZE),
      .COLOR_BITS      (COLOR_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_line_color   (req_line_color),
      .req_stroke_width (req_stroke_width),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .ent_valid        (push_valid),
      .ent_ready        (push_ready),
      .ent_kind         (push_ent.kind),
      .ent_pos_a        (push_ent.pos_a),
      .ent_pos_b        (push_ent.pos_b),
      .ent_size_a       (push_ent.size_a),
      .ent_size_b       (push_ent.size_b),
      .ent_major_end    (push_ent.major_end),
      .ent_swapped      (push_ent.swapped),
      .ent_color        (push_ent.color),
      .ent_stroke       (push_ent.stroke)
   );

   // command queue
   tlr_queue #(
      .WIDTH ($bits(qent_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_ent),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_ent)
   );

   // walker and result register
   tlr_back #(
      .MAX_SCREEN_SIZE (MAX_SCREEN_SIZE),
      .COLOR_BITS      (COLOR_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (pop_valid),
      .q_pop          (pop),
      .q_kind         (pop_ent.kind),
      .q_pos_a        (pop_ent.pos_a),
      .q_pos_b        (pop_ent.pos_b),
      .q_size_a       (pop_ent.size_a),
      .q_size_b       (pop_ent.size_b),
      .q_major_end    (pop_ent.major_end),
      .q_swapped      (pop_ent.swapped),
      .q_color        (pop_ent.color),
      .q_stroke       (pop_ent.stroke),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rect_x     (rsp_rect_x),
      .rsp_rect_y     (rsp_rect_y),
      .rsp_rect_w     (rsp_rect_w),
      .rsp_rect_h     (rsp_rect_h),
      .rsp_rect_color (rsp_rect_color),
      .rsp_last       (rsp_last)
   );

endmodule

// File: sv/tlr_front.sv
// ----------------------------------------------------------------------------
// tlr_front
// Front end: takes requests, clamps endpoints to the screen and classifies
// each start into a straight rectangle or a diagonal setup for the walker.
// ----------------------------------------------------------------------------
module tlr_front import tlr_pkg::*; #(
   parameter int MAX_SCREEN_SIZE = 4096,
   parameter int COLOR_BITS = 16,
   localparam int CW = $clog2(MAX_SCREEN_SIZE),
   localparam int SZ = (CW > STROKE_W) ? CW : STROKE_W,
   localparam int CB = (COLOR_BITS < COLOR_IN_W) ? COLOR_BITS : COLOR_IN_W
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic signed [COORD_IN_W-1:0]  req_start_x,
   input  logic signed [COORD_IN_W-1:0]  req_start_y,
   input  logic signed [COORD_IN_W-1:0]  req_end_x,
   input  logic signed [COORD_IN_W-1:0]  req_end_y,
   input  logic [COLOR_IN_W-1:0]         req_line_color,
   input  logic [STROKE_W-1:0]           req_stroke_width,
   // register writes
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [CSR_W-1:0]              csr_wdata,
   // command to the queue
   output logic                          ent_valid,
   input  logic                          ent_ready,
   output cmd_type                       ent_kind,
   output logic signed [SZ:0]            ent_pos_a,
   output logic signed [SZ:0]            ent_pos_b,
   output logic [SZ-1:0]                 ent_size_a,
   output logic [SZ-1:0]                 ent_size_b,
   output logic [CW-1:0]                 ent_major_end,
   output logic                          ent_swapped,
   output logic [CB-1:0]                 ent_color,
   output logic [STROKE_W-1:0]           ent_stroke
);

   localparam int PW  = SZ + 1;
   localparam int EXW = (CSR_W > CW + 1) ? CSR_W : CW + 1;
   localparam int LIM_X_RESET =
      ((SCREEN_WIDTH_RESET > MAX_SCREEN_SIZE) ? MAX_SCREEN_SIZE : SCREEN_WIDTH_RESET) - 1;
   localparam int LIM_Y_RESET =
      ((SCREEN_HEIGHT_RESET > MAX_SCREEN_SIZE) ? MAX_SCREEN_SIZE : SCREEN_HEIGHT_RESET) - 1;

   // largest legal column and row
   logic [CW-1:0] lim_x_ff, lim_y_ff, lim_in;

   // classify stage registers
   logic                a_valid_ff;
   logic                a_op_ff;
   logic [CW-1:0]       a_x1_ff, a_y1_ff, a_x2_ff, a_y2_ff;
   logic [CB-1:0]       a_color_ff;
   logic [STROKE_W-1:0] a_stroke_ff;

   logic [STROKE_W-1:0] stroke_in;
   logic [STROKE_W-2:0] half;
   logic [CW-1:0]       min_x, min_y, dx, dy;
   logic [CW-1:0]       maj_from, maj_to, min_from;
   logic                x_eq, y_eq, x_gt, y_gt, swapped, flip;

   // register value to largest coordinate: zero acts as one, cap at max size
   always_comb begin
      if (csr_wdata == '0) begin
         lim_in = '0;
      end else if (EXW'(csr_wdata) > EXW'(MAX_SCREEN_SIZE)) begin
         lim_in = CW'(MAX_SCREEN_SIZE - 1);
      end else begin
         lim_in = CW'(csr_wdata - CSR_W'(1));
      end
   end

   // screen limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lim_x_ff <= CW'(LIM_X_RESET);
         lim_y_ff <= CW'(LIM_Y_RESET);
      end else if (csr_write_en) begin
         if (csr_index == CSR_SCREEN_WIDTH) begin
            lim_x_ff <= lim_in;
         end
         if (csr_index == CSR_SCREEN_HEIGHT) begin
            lim_y_ff <= lim_in;
         end
      end
   end

   function automatic logic [CW-1:0] clamp_coord(input logic signed [COORD_IN_W-1:0] v,
                                                 input logic [CW-1:0] lim);
      logic [COORD_IN_W-1:0] mag;
      mag = {1'b0, v[COORD_IN_W-2:0]};
      if (v[COORD_IN_W-1]) begin
         return '0;
      end else if (mag > COORD_IN_W'(lim)) begin
         return lim;
      end else begin
         return CW'(mag);
      end
   endfunction

   // the stage moves on whenever the queue has room
   assign req_stall = a_valid_ff && !ent_ready;
   assign stroke_in = (req_stroke_width == '0) ? STROKE_W'(1) : req_stroke_width;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!a_valid_ff || ent_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   // clamp and hold the request
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         a_op_ff     <= req_op;
         a_x1_ff     <= clamp_coord(req_start_x, lim_x_ff);
         a_y1_ff     <= clamp_coord(req_start_y, lim_y_ff);
         a_x2_ff     <= clamp_coord(req_end_x, lim_x_ff);
         a_y2_ff     <= clamp_coord(req_end_y, lim_y_ff);
         a_color_ff  <= req_line_color[CB-1:0];
         a_stroke_ff <= stroke_in;
      end
   end

   // geometry of the clamped line
   always_comb begin
      half  = a_stroke_ff[STROKE_W-1:1];
      x_gt  = a_x1_ff > a_x2_ff;
      y_gt  = a_y1_ff > a_y2_ff;
      x_eq  = a_x1_ff == a_x2_ff;
      y_eq  = a_y1_ff == a_y2_ff;
      min_x = x_gt ? a_x2_ff : a_x1_ff;
      min_y = y_gt ? a_y2_ff : a_y1_ff;
      dx    = x_gt ? a_x1_ff - a_x2_ff : a_x2_ff - a_x1_ff;
      dy    = y_gt ? a_y1_ff - a_y2_ff : a_y2_ff - a_y1_ff;
      swapped = dx < dy;
      // the minor axis always runs upward, so the major ends trade places
      flip  = swapped ? x_gt : y_gt;
      if (swapped) begin
         maj_from = flip ? a_y2_ff : a_y1_ff;
         maj_to   = flip ? a_y1_ff : a_y2_ff;
         min_from = min_x;
      end else begin
         maj_from = flip ? a_x2_ff : a_x1_ff;
         maj_to   = flip ? a_x1_ff : a_x2_ff;
         min_from = min_y;
      end
   end

   // build the command
   always_comb begin
      ent_valid     = a_valid_ff;
      ent_color     = a_color_ff;
      ent_stroke    = a_stroke_ff;
      ent_swapped   = swapped;
      ent_major_end = maj_to;
      ent_pos_a     = $signed(PW'(min_x)) - $signed(PW'(half));
      ent_pos_b     = $signed(PW'(min_y)) - $signed(PW'(half));
      ent_size_a    = SZ'(dx);
      ent_size_b    = SZ'(a_stroke_ff);
      if (a_op_ff == OP_NEXT) begin
         ent_kind = CMD_NEXT;
      end else if (y_eq) begin
         ent_kind = CMD_RECT;
      end else if (x_eq) begin
         ent_kind   = CMD_RECT;
         ent_size_a = SZ'(a_stroke_ff);
         ent_size_b = SZ'(dy);
      end else begin
         ent_kind   = CMD_LINE;
         ent_pos_a  = $signed(PW'(maj_from));
         ent_pos_b  = $signed(PW'(min_from));
         ent_size_a = SZ'(swapped ? dy : dx);
         ent_size_b = SZ'(swapped ? dx : dy);
      end
   end

endmodule

// File: sv/tlr_queue.sv
// ----------------------------------------------------------------------------
// tlr_queue
// Short command queue between the front end and the walker.
// ----------------------------------------------------------------------------
module tlr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != (AW + 1)'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = mem[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/tlr_back.sv
// ----------------------------------------------------------------------------
// tlr_back
// Walker: runs commands from the queue, steps the major axis with an exact
// error term and drives the registered result channel.
// ----------------------------------------------------------------------------
module tlr_back import tlr_pkg::*; #(
   parameter int MAX_SCREEN_SIZE = 4096,
   parameter int COLOR_BITS = 16,
   localparam int CW = $clog2(MAX_SCREEN_SIZE),
   localparam int SZ = (CW > STROKE_W) ? CW : STROKE_W,
   localparam int CB = (COLOR_BITS < COLOR_IN_W) ? COLOR_BITS : COLOR_IN_W
) (
   input  logic                          clock,
   input  logic                          reset,
   // command from the queue
   input  logic                          q_valid,
   output logic                          q_pop,
   input  cmd_type                       q_kind,
   input  logic signed [SZ:0]            q_pos_a,
   input  logic signed [SZ:0]            q_pos_b,
   input  logic [SZ-1:0]                 q_size_a,
   input  logic [SZ-1:0]                 q_size_b,
   input  logic [CW-1:0]                 q_major_end,
   input  logic                          q_swapped,
   input  logic [CB-1:0]                 q_color,
   input  logic [STROKE_W-1:0]           q_stroke,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [RECT_POS_W-1:0]  rsp_rect_x,
   output logic signed [RECT_POS_W-1:0]  rsp_rect_y,
   output logic [RECT_DIM_W-1:0]         rsp_rect_w,
   output logic [RECT_DIM_W-1:0]         rsp_rect_h,
   output logic [COLOR_IN_W-1:0]         rsp_rect_color,
   output logic                          rsp_last
);

   localparam int PW = SZ + 1;
   localparam int EW = CW + 2;

   // line state
   logic                active_ff, active_in;
   logic [CW-1:0]       major_pos_ff, major_pos_in;
   logic [CW-1:0]       major_end_ff, major_end_in;
   logic                step_down_ff, step_down_in;
   logic [CW-1:0]       minor_pos_ff, minor_pos_in;
   logic signed [EW-1:0] error_ff, error_in;
   logic [CW-1:0]       major_delta_ff, major_delta_in;
   logic [CW-1:0]       minor_delta_ff, minor_delta_in;
   logic                swapped_ff, swapped_in;
   logic [CB-1:0]       color_ff, color_in;
   logic [STROKE_W-1:0] stroke_ff, stroke_in;

   // result registers
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [RECT_POS_W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [RECT_DIM_W-1:0]         rsp_w_ff, rsp_w_in, rsp_h_ff, rsp_h_in;
   logic [COLOR_IN_W-1:0]         rsp_color_ff, rsp_color_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                 produces, out_free, fin;
   logic [CW-1:0]        px, py;
   logic signed [PW-1:0] sq_x, sq_y;
   logic signed [EW-1:0] err_add, err_both;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rect_x     = rsp_x_ff;
   assign rsp_rect_y     = rsp_y_ff;
   assign rsp_rect_w     = rsp_w_ff;
   assign rsp_rect_h     = rsp_h_ff;
   assign rsp_rect_color = rsp_color_ff;
   assign rsp_last       = rsp_last_ff;

   // issue control: commands without a result never wait on the output
   always_comb begin
      produces = (q_kind == CMD_RECT) || ((q_kind == CMD_NEXT) && active_ff);
      out_free = !rsp_valid_ff || !rsp_stall;
      q_pop    = q_valid && (out_free || !produces);
   end

   // current square and the error step
   always_comb begin
      px       = swapped_ff ? minor_pos_ff : major_pos_ff;
      py       = swapped_ff ? major_pos_ff : minor_pos_ff;
      sq_x     = $signed(PW'(px)) - $signed(PW'(stroke_ff[STROKE_W-1:1]));
      sq_y     = $signed(PW'(py)) - $signed(PW'(stroke_ff[STROKE_W-1:1]));
      fin      = major_pos_ff == major_end_ff;
      err_add  = error_ff + $signed(EW'(minor_delta_ff));
      err_both = err_add - $signed(EW'(major_delta_ff));
   end

   // next state
   always_comb begin
      active_in      = active_ff;
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      step_down_in   = step_down_ff;
      minor_pos_in   = minor_pos_ff;
      error_in       = error_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      swapped_in     = swapped_ff;
      color_in       = color_ff;
      stroke_in      = stroke_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_w_in       = rsp_w_ff;
      rsp_h_in       = rsp_h_ff;
      rsp_color_in   = rsp_color_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = out_free ? (q_pop && produces) : rsp_valid_ff;
      if (q_pop) begin
         unique case (q_kind)
            CMD_RECT: begin
               active_in    = 1'b0;
               color_in     = q_color;
               stroke_in    = q_stroke;
               rsp_x_in     = RECT_POS_W'(q_pos_a);
               rsp_y_in     = RECT_POS_W'(q_pos_b);
               rsp_w_in     = RECT_DIM_W'(q_size_a);
               rsp_h_in     = RECT_DIM_W'(q_size_b);
               rsp_color_in = COLOR_IN_W'(q_color);
               rsp_last_in  = 1'b1;
            end
            CMD_LINE: begin
               active_in      = 1'b1;
               color_in       = q_color;
               stroke_in      = q_stroke;
               swapped_in     = q_swapped;
               major_pos_in   = q_pos_a[CW-1:0];
               minor_pos_in   = q_pos_b[CW-1:0];
               major_end_in   = q_major_end;
               step_down_in   = q_pos_a[CW-1:0] > q_major_end;
               major_delta_in = q_size_a[CW-1:0];
               minor_delta_in = q_size_b[CW-1:0];
               error_in       = $signed(EW'(q_size_b[CW-1:0]))
                              - $signed(EW'(q_size_a[CW-1:0]));
            end
            CMD_NEXT: begin
               if (active_ff) begin
                  rsp_x_in     = RECT_POS_W'(sq_x);
                  rsp_y_in     = RECT_POS_W'(sq_y);
                  rsp_w_in     = RECT_DIM_W'(stroke_ff);
                  rsp_h_in     = RECT_DIM_W'(stroke_ff);
                  rsp_color_in = COLOR_IN_W'(color_ff);
                  rsp_last_in  = fin;
                  if (fin) begin
                     active_in = 1'b0;
                  end else begin
                     major_pos_in = step_down_ff ? major_pos_ff - 1'b1
                                                 : major_pos_ff + 1'b1;
                     // minor step when the term turns positive
                     if (!err_add[EW-1] && (err_add != '0)) begin
                        minor_pos_in = minor_pos_ff + 1'b1;
                        error_in     = err_both;
                     end else begin
                        error_in = err_add;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      major_pos_ff   <= major_pos_in;
      major_end_ff   <= major_end_in;
      step_down_ff   <= step_down_in;
      minor_pos_ff   <= minor_pos_in;
      error_ff       <= error_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      swapped_ff     <= swapped_in;
      color_ff       <= color_in;
      stroke_ff      <= stroke_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_w_ff       <= rsp_w_in;
      rsp_h_ff       <= rsp_h_in;
      rsp_color_ff   <= rsp_color_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the thick line rasterizer.
// Requests come from a queue that the stimulus block fills. The driver
// predicts each rectangle as its request transfers, and the monitor checks
// every result transfer against the oldest prediction. Random gaps on both
// channels run through several screen settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
   import tlr_pkg::*;

   localparam int MAX_SCREEN    = 4096;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASE_ITEMS   = 300;
   localparam int NUM_PHASES    = 6;

   typedef struct packed {
      logic                  op;
      logic [COORD_IN_W-1:0] start_x;
      logic [COORD_IN_W-1:0] start_y;
      logic [COORD_IN_W-1:0] end_x;
      logic [COORD_IN_W-1:0] end_y;
      logic [COLOR_IN_W-1:0] line_color;
      logic [STROKE_W-1:0]   stroke_width;
      logic                  drain_first;
   } line_cmd_type;

   typedef struct packed {
      logic signed [RECT_POS_W-1:0] x;
      logic signed [RECT_POS_W-1:0] y;
      logic [RECT_DIM_W-1:0]        w;
      logic [RECT_DIM_W-1:0]        h;
      logic [COLOR_IN_W-1:0]        color;
      logic                         last;
   } rect_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid        = 1'b0;
   logic                         req_stall;
   logic                         req_op           = OP_START;
   logic signed [COORD_IN_W-1:0] req_start_x      = '0;
   logic signed [COORD_IN_W-1:0] req_start_y      = '0;
   logic signed [COORD_IN_W-1:0] req_end_x        = '0;
   logic signed [COORD_IN_W-1:0] req_end_y        = '0;
   logic [COLOR_IN_W-1:0]        req_line_color   = '0;
   logic [STROKE_W-1:0]          req_stroke_width = '0;

   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [RECT_POS_W-1:0] rsp_rect_x;
   logic signed [RECT_POS_W-1:0] rsp_rect_y;
   logic [RECT_DIM_W-1:0]        rsp_rect_w;
   logic [RECT_DIM_W-1:0]        rsp_rect_h;
   logic [COLOR_IN_W-1:0]        rsp_rect_color;
   logic                         rsp_last;

   logic             csr_write_en = 1'b0;
   logic             csr_index    = CSR_SCREEN_WIDTH;
   logic [CSR_W-1:0] csr_wdata    = '0;

   // pending requests and predicted rectangles
   line_cmd_type line_cmds[$];
   rect_type     expected_rects[$];

   int cycle_count  = 0;
   int pushed_cnt   = 0;
   int accepted_cnt = 0;
   int checked_cnt  = 0;
   int mismatches   = 0;

   // windows in which neither side idles
   wire steady = (cycle_count % 1000) < 200;

   // predictor copy of the registers and the line walker
   logic [CSR_W-1:0] cfg_width  = CSR_W'(SCREEN_WIDTH_RESET);
   logic [CSR_W-1:0] cfg_height = CSR_W'(SCREEN_HEIGHT_RESET);
   bit   walk_on;
   int   walk_major, walk_major_end, walk_minor, walk_err;
   int   walk_major_d, walk_minor_d;
   bit   walk_down, walk_swapped;
   logic [COLOR_IN_W-1:0] walk_color;
   int   walk_stroke;

   thick_line_rasterizer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_line_color   (req_line_color),
      .req_stroke_width (req_stroke_width),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rect_x       (rsp_rect_x),
      .rsp_rect_y       (rsp_rect_y),
      .rsp_rect_w       (rsp_rect_w),
      .rsp_rect_h       (rsp_rect_h),
      .rsp_rect_color   (rsp_rect_color),
      .rsp_last         (rsp_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register value as the block uses it
   function automatic int screen_extent(logic [CSR_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_SCREEN) return MAX_SCREEN;
      return int'(value);
   endfunction

   function automatic int clamp_coord(int v, int extent);
      if (v < 0) return 0;
      if (v >= extent) return extent - 1;
      return v;
   endfunction

   function automatic int abs_int(int v);
      return (v < 0) ? -v : v;
   endfunction

   // most gaps short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // predicts the rectangle a request causes, if any, and advances the walker
   function automatic bit rasterize_item(input line_cmd_type c, output rect_type r);
      int sw, sh, x1, y1, x2, y2, s, half, fx, fy, dx, dy;
      int maj_from, maj_to, min_from, min_to, t, px, py;
      bit fin;
      r = '0;
      if (c.op == OP_START) begin
         sw = screen_extent(cfg_width);
         sh = screen_extent(cfg_height);
         x1 = clamp_coord(int'($signed(c.start_x)), sw);
         y1 = clamp_coord(int'($signed(c.start_y)), sh);
         x2 = clamp_coord(int'($signed(c.end_x)), sw);
         y2 = clamp_coord(int'($signed(c.end_y)), sh);
         s = (c.stroke_width == 0) ? 1 : int'(c.stroke_width);
         walk_stroke = s;
         walk_color = c.line_color;
         half = s / 2;
         fx = ((x1 < x2) ? x1 : x2) - half;
         fy = ((y1 < y2) ? y1 : y2) - half;
         dx = abs_int(x2 - x1);
         dy = abs_int(y2 - y1);
         r.color = walk_color;
         r.last = 1'b1;
         r.x = fx[RECT_POS_W-1:0];
         r.y = fy[RECT_POS_W-1:0];
         // straight lines come back as one rectangle at once
         if (y1 == y2) begin
            walk_on = 1'b0;
            r.w = dx[RECT_DIM_W-1:0];
            r.h = s[RECT_DIM_W-1:0];
            return 1'b1;
         end
         if (x1 == x2) begin
            walk_on = 1'b0;
            r.w = s[RECT_DIM_W-1:0];
            r.h = dy[RECT_DIM_W-1:0];
            return 1'b1;
         end
         // diagonal: set up the walk, minor axis always runs upward
         if (dx < dy) begin
            walk_swapped = 1'b1;
            walk_major_d = dy;
            walk_minor_d = dx;
            maj_from = y1; maj_to = y2; min_from = x1; min_to = x2;
         end else begin
            walk_swapped = 1'b0;
            walk_major_d = dx;
            walk_minor_d = dy;
            maj_from = x1; maj_to = x2; min_from = y1; min_to = y2;
         end
         if (min_from > min_to) begin
            t = maj_from;
            maj_from = maj_to;
            maj_to = t;
            min_from = min_to;
         end
         walk_major = maj_from;
         walk_major_end = maj_to;
         walk_down = maj_from > maj_to;
         walk_minor = min_from;
         walk_err = walk_minor_d - walk_major_d;
         walk_on = 1'b1;
         return 1'b0;
      end
      if (!walk_on) return 1'b0;
      px = walk_swapped ? walk_minor : walk_major;
      py = walk_swapped ? walk_major : walk_minor;
      fin = (walk_major == walk_major_end);
      if (walk_stroke > 1) begin
         px = px - walk_stroke / 2;
         py = py - walk_stroke / 2;
         r.w = walk_stroke[RECT_DIM_W-1:0];
         r.h = walk_stroke[RECT_DIM_W-1:0];
      end else begin
         r.w = RECT_DIM_W'(1);
         r.h = RECT_DIM_W'(1);
      end
      r.x = px[RECT_POS_W-1:0];
      r.y = py[RECT_POS_W-1:0];
      r.color = walk_color;
      r.last = fin;
      if (fin) begin
         walk_on = 1'b0;
      end else begin
         walk_major = walk_major + (walk_down ? -1 : 1);
         walk_err = walk_err + walk_minor_d;
         if (walk_err > 0) begin
            walk_minor = walk_minor + 1;
            walk_err = walk_err - walk_major_d;
         end
      end
      return 1'b1;
   endfunction

   // request driver: predicts on each transfer, then presents the next item
   line_cmd_type cur_cmd;
   rect_type     next_rect;
   int           gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (rasterize_item(cur_cmd, next_rect)) expected_rects.push_back(next_rect);
            accepted_cnt++;
            if (!steady) gap_left = pick_gap();
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (line_cmds.size() != 0 &&
                         !(line_cmds[0].drain_first && expected_rects.size() != 0)) begin
               cur_cmd = line_cmds.pop_front();
               req_valid        <= 1'b1;
               req_op           <= cur_cmd.op;
               req_start_x      <= cur_cmd.start_x;
               req_start_y      <= cur_cmd.start_y;
               req_end_x        <= cur_cmd.end_x;
               req_end_y        <= cur_cmd.end_y;
               req_line_color   <= cur_cmd.line_color;
               req_stroke_width <= cur_cmd.stroke_width;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and random stall
   rect_type got_rect, want_rect;
   int       stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_rect.x     = rsp_rect_x;
            got_rect.y     = rsp_rect_y;
            got_rect.w     = rsp_rect_w;
            got_rect.h     = rsp_rect_h;
            got_rect.color = rsp_rect_color;
            got_rect.last  = rsp_last;
            if (expected_rects.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected rectangle x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
                           got_rect.x, got_rect.y, got_rect.w, got_rect.h,
                           got_rect.color, got_rect.last);
            end else begin
               want_rect = expected_rects.pop_front();
               checked_cnt++;
               if (got_rect.x !== want_rect.x || got_rect.y !== want_rect.y ||
                   got_rect.w !== want_rect.w || got_rect.h !== want_rect.h ||
                   got_rect.color !== want_rect.color || got_rect.last !== want_rect.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("rect %0d expected x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
                              checked_cnt, want_rect.x, want_rect.y, want_rect.w,
                              want_rect.h, want_rect.color, want_rect.last);
                     $display("rect %0d actual   x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
                              checked_cnt, got_rect.x, got_rect.y, got_rect.w,
                              got_rect.h, got_rect.color, got_rect.last);
                  end
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!steady && $urandom_range(0, 2) == 0) stall_left = pick_gap();
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic push_start(int sx, int sy, int ex, int ey, int color, int stroke);
      line_cmd_type c;
      c.op           = OP_START;
      c.start_x      = sx[COORD_IN_W-1:0];
      c.start_y      = sy[COORD_IN_W-1:0];
      c.end_x        = ex[COORD_IN_W-1:0];
      c.end_y        = ey[COORD_IN_W-1:0];
      c.line_color   = color[COLOR_IN_W-1:0];
      c.stroke_width = stroke[STROKE_W-1:0];
      c.drain_first  = 1'b0;
      line_cmds.push_back(c);
      pushed_cnt++;
   endtask

   // next requests carry random junk in the unused fields
   task automatic push_next(int n);
      line_cmd_type c;
      repeat (n) begin
         c.op           = OP_NEXT;
         c.start_x      = COORD_IN_W'($urandom);
         c.start_y      = COORD_IN_W'($urandom);
         c.end_x        = COORD_IN_W'($urandom);
         c.end_y        = COORD_IN_W'($urandom);
         c.line_color   = COLOR_IN_W'($urandom);
         c.stroke_width = STROKE_W'($urandom);
         c.drain_first  = 1'b0;
         line_cmds.push_back(c);
         pushed_cnt++;
      end
   endtask

   // wait until every request transferred and every rectangle came back
   task automatic settle();
      while (accepted_cnt != pushed_cnt || expected_rects.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic index, int value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value[CSR_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (index == CSR_SCREEN_WIDTH) cfg_width = value[CSR_W-1:0];
      else cfg_height = value[CSR_W-1:0];
   endtask

   // stimulus
   int phase_w[NUM_PHASES] = '{320, 0, 4096, 8191, 37, 320};
   int phase_h[NUM_PHASES] = '{240, 0, 8191, 1, 4097, 240};

   initial begin
      int p, count, kind, span, x1, y1, x2, y2, d, n, ew, eh;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, clamping, straight lines, walks both ways
      push_start(-32768, 100, 32767, 100, 16'hFFFF, 63);
      push_start(5, 32767, 5, -32768, 16'h0000, 2);
      push_start(319, 239, 319, 239, 16'h5A5A, 0);
      push_next(1);
      push_start(10, 10, 14, 12, 16'h1234, 1);
      push_next(5);
      push_start(20, 30, 18, 24, 16'hA5C3, 5);
      push_next(7);
      // walk right to left with minor rising, abandoned part way
      push_start(100, 50, 90, 60, 16'h0F0F, 3);
      push_next(2);
      push_start(0, 0, 7, 0, 16'hF0F0, 1);
      push_next(1);

      for (p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) begin
            settle();
            write_reg(CSR_SCREEN_WIDTH, phase_w[p]);
            write_reg(CSR_SCREEN_HEIGHT, phase_h[p]);
         end
         ew = screen_extent(phase_w[p][CSR_W-1:0]);
         eh = screen_extent(phase_h[p][CSR_W-1:0]);
         count = 0;
         while (count < PHASE_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
               // well-formed line inside the screen, mostly short
               span = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 300)
                                                   : $urandom_range(1, 16);
               x1 = $urandom_range(0, ew - 1);
               y1 = $urandom_range(0, eh - 1);
               d = $urandom_range(0, 2 * span);
               x2 = clamp_coord(x1 + d - span, ew);
               d = $urandom_range(0, 2 * span);
               y2 = clamp_coord(y1 + d - span, eh);
               push_start(x1, y1, x2, y2, $urandom, $urandom_range(0, 63));
               if (count == 0 || $urandom_range(0, 99) == 0)
                  line_cmds[line_cmds.size() - 1].drain_first = 1'b1;
               n = (x1 == x2 || y1 == y2) ? 0
                 : ((abs_int(x2 - x1) > abs_int(y2 - y1)) ? abs_int(x2 - x1)
                                                           : abs_int(y2 - y1)) + 1;
               if (n != 0 && $urandom_range(0, 99) < 15) n = $urandom_range(0, n - 1);
               push_next(n);
               count += 1 + n;
               if ($urandom_range(0, 9) == 0) push_next(1);
            end else if (kind < 80) begin
               // straight line
               x1 = $urandom_range(0, ew - 1);
               y1 = $urandom_range(0, eh - 1);
               if ($urandom_range(0, 1) == 0)
                  push_start(x1, y1, $urandom_range(0, ew - 1), y1, $urandom,
                             $urandom_range(0, 63));
               else
                  push_start(x1, y1, x1, $urandom_range(0, eh - 1), $urandom,
                             $urandom_range(0, 63));
               count++;
            end else if (kind < 95) begin
               // full-range endpoints, clamped, usually left unfinished
               push_start($urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(0, 63));
               n = $urandom_range(0, 6);
               push_next(n);
               count += 1 + n;
            end else begin
               push_next($urandom_range(1, 3));
            end
         end
      end

      settle();
      $display("%0d requests, %0d rectangles checked over %0d screen settings",
               accepted_cnt, checked_cnt, NUM_PHASES);
      $display("screens from 1x1 up to clamped 4096, strokes 0 to 63, walks both ways");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/tlr_pkg.sv
sv/tlr_front.sv
sv/tlr_queue.sv
sv/tlr_back.sv
sv/thick_line_rasterizer.sv
tb/sv/tb.sv
